>>> hdl/sqkg_pkg.sv
// sqkg_pkg: shared types, pattern texts and codes for the sql keyword guard
// no dependencies; imported by every module of the block
package sqkg_pkg;

    // pattern set: destructive keywords, markers, tenant clause
    localparam int unsigned NUM_FIXED     = 10;
    localparam int unsigned MAX_FIXED_LEN = 15;
    localparam int unsigned NUM_SEEN      = 11;

    // positions in the seen vector
    localparam int unsigned SEEN_DESTR_HI  = 5;
    localparam int unsigned SEEN_MARK_LO   = 6;
    localparam int unsigned SEEN_MARK_HI   = 8;
    localparam int unsigned SEEN_CLAUSE    = 9;
    localparam int unsigned SEEN_FORGED    = 10;

    // name of the owner key column, as ascii bytes
    localparam logic [71:0] OWNER_COL = 72'h74_65_6e_61_6e_74_5f_69_64;

    // texts are right aligned: last character sits in bits 7:0
    localparam logic [8*MAX_FIXED_LEN-1:0] PAT_TEXT [NUM_FIXED] = '{
        "drop table", "drop database", "alter system", "truncate ",
        "drop schema", "grant all", {"where ", OWNER_COL}, "/*", "--", {OWNER_COL, " ="}
    };
    localparam int unsigned PAT_LEN [NUM_FIXED] = '{
        10, 13, 12, 9, 11, 9, 15, 2, 2, 11
    };

    // head of the forged tenant pattern, right aligned in 16 bytes
    localparam int unsigned FORGED_HEAD_LEN = 13;
    localparam logic [127:0] FORGED_HEAD    = {OWNER_COL, " = '"};
    localparam logic [7:0]   QUOTE_CHAR     = 8'h27;

    // verdict codes
    localparam logic [1:0] VERDICT_OK     = 2'd0;
    localparam logic [1:0] VERDICT_DESTR  = 2'd1;
    localparam logic [1:0] VERDICT_BYPASS = 2'd2;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ADMIN       = 2'd0,
        CFG_TENANT_LEN  = 2'd1,
        CFG_TENANT_LOW  = 2'd2,
        CFG_TENANT_HIGH = 2'd3
    } cfg_idx_t;

    // per-query summary after the current item is folded in
    typedef struct packed {
        logic [NUM_SEEN-1:0] seen;
        logic                nonempty;
    } qry_sum_t;

    // bytes of history the window must hold
    function automatic int unsigned recent_depth(int unsigned max_tenant);
        int unsigned need;
        need = FORGED_HEAD_LEN + max_tenant;
        return (need > MAX_FIXED_LEN - 1) ? need : MAX_FIXED_LEN - 1;
    endfunction

    // fold ascii upper case letters to lower case
    function automatic logic [7:0] fold_lower(logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> hdl/sqkg_match.sv
// sqkg_match: compares the byte window against all patterns in parallel
// depends on sqkg_pkg
module sqkg_match #(
    parameter int unsigned CNT_W            = 11,
    parameter int unsigned DEPTH            = 29
) (
    input  logic [7:0]                  cur_byte,
    input  logic [8*DEPTH-1:0]          window,
    input  logic [CNT_W-1:0]            bytes_taken,
    input  logic [4:0]                  tenant_len,
    input  logic [63:0]                 tenant_low,
    input  logic [63:0]                 tenant_high,
    output logic [sqkg_pkg::NUM_SEEN-1:0] hits
);
    import sqkg_pkg::*;

    logic [8*(DEPTH+1)-1:0] wall;
    logic [127:0]           tenant_all;
    logic [NUM_FIXED-1:0]   fixed_hits;
    logic                   forged_hit;

    assign wall       = {window, cur_byte};
    assign tenant_all = {tenant_high, tenant_low};
    assign hits       = {forged_hit, fixed_hits};

    // fixed patterns: byte at distance d back against text from the end
    always_comb
    begin
        logic ok;
        fixed_hits = '0;
        for (int p = 0; p < NUM_FIXED; p++)
        begin
            ok = (bytes_taken >= CNT_W'(PAT_LEN[p] - 1));
            for (int d = 0; d < MAX_FIXED_LEN; d++)
            begin
                if (d < PAT_LEN[p] && wall[8*d +: 8] != PAT_TEXT[p][8*d +: 8])
                begin
                    ok = 1'b0;
                end
            end
            fixed_hits[p] = ok;
        end
    end

    // forged tenant pattern: quote, tenant bytes reversed, then the head
    always_comb
    begin
        logic       ok;
        logic [5:0] n6;
        logic [5:0] j6;
        logic [5:0] e6;
        logic [7:0] expect_b;
        n6 = {1'b0, tenant_len};
        ok = (tenant_len != 5'd0) &&
             (bytes_taken >= CNT_W'(n6) + CNT_W'(FORGED_HEAD_LEN));
        for (int d = 0; d <= DEPTH; d++)
        begin
            j6 = n6 - 6'(d);
            e6 = 6'(d) - n6 - 6'd1;
            if (d == 0)
            begin
                expect_b = QUOTE_CHAR;
            end
            else if (6'(d) <= n6)
            begin
                expect_b = tenant_all[{j6[3:0], 3'b000} +: 8];
            end
            else
            begin
                expect_b = FORGED_HEAD[{e6[3:0], 3'b000} +: 8];
            end
            if (6'(d) <= n6 + 6'(FORGED_HEAD_LEN) && wall[8*d +: 8] != expect_b)
            begin
                ok = 1'b0;
            end
        end
        forged_hit = ok;
    end

endmodule

>>> hdl/sqkg_track.sv
// sqkg_track: per-query state: byte window, seen flags, byte count, end flag
// depends on sqkg_pkg; fed by the hit vector of sqkg_match
module sqkg_track #(
    parameter int unsigned MAX_QUERY_BYTES = 2047,
    parameter int unsigned CNT_W           = 11,
    parameter int unsigned DEPTH           = 29
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic                          last,
    input  logic [7:0]                    cur_byte,
    input  logic [sqkg_pkg::NUM_SEEN-1:0] hits,
    output logic [8*DEPTH-1:0]            window,
    output logic [CNT_W-1:0]              bytes_taken,
    output sqkg_pkg::qry_sum_t            summary
);
    import sqkg_pkg::*;

    logic [8*DEPTH-1:0]  win_reg,   win_next,   win_upd;
    logic [NUM_SEEN-1:0] seen_reg,  seen_next,  seen_upd;
    logic [CNT_W-1:0]    count_reg, count_next, count_upd;
    logic                ended_reg, ended_next, ended_upd;

    // fold the current item into the query state
    always_comb
    begin
        win_upd   = win_reg;
        seen_upd  = seen_reg;
        count_upd = count_reg;
        ended_upd = ended_reg;
        if (take && !ended_reg)
        begin
            if (cur_byte == 8'd0)
            begin
                ended_upd = 1'b1;
            end
            else
            begin
                win_upd   = {win_reg[8*DEPTH-9:0], cur_byte};
                seen_upd  = seen_reg | hits;
                count_upd = count_reg + CNT_W'(1);
                if (count_upd >= CNT_W'(MAX_QUERY_BYTES))
                begin
                    ended_upd = 1'b1;
                end
            end
        end
    end

    // last item of a query clears everything for the next one
    always_comb
    begin
        if (take && last)
        begin
            win_next   = '0;
            seen_next  = '0;
            count_next = '0;
            ended_next = 1'b0;
        end
        else
        begin
            win_next   = win_upd;
            seen_next  = seen_upd;
            count_next = count_upd;
            ended_next = ended_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            seen_reg  <= '0;
            count_reg <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            win_reg   <= win_next;
            seen_reg  <= seen_next;
            count_reg <= count_next;
            ended_reg <= ended_next;
        end
    end

    assign window           = win_reg;
    assign bytes_taken      = count_reg;
    assign summary.seen     = seen_upd;
    assign summary.nonempty = (count_upd != '0);

endmodule

>>> hdl/sql_keyword_guard_top.sv
// sql_keyword_guard_top: input register, pattern match, query state, verdict register
// depends on sqkg_pkg, sqkg_match, sqkg_track
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  in       | in_valid/in_ready, query_byte,   | into block
//           | last_byte                        |
//  out      | out_valid/out_ready, verdict,    | out of block
//           | prepend_tenant                   |
//  cfg      | cfg_we, cfg_index, cfg_data      | into block
//
// one item per cycle while no last item waits on a stalled verdict; an item is matched in the cycle after it is taken
// the verdict of a query is registered once its last item leaves the input register
// a stalled verdict holds only a following last item; other items keep flowing
// reset clears configuration, query state and both valid flags
module sql_keyword_guard_top #(
    parameter int unsigned MAX_QUERY_BYTES  = 2047,
    parameter int unsigned MAX_TENANT_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  query_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  verdict,
    output logic        prepend_tenant,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import sqkg_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_QUERY_BYTES + 1);
    localparam int unsigned DEPTH = recent_depth(MAX_TENANT_BYTES);

    logic        admin_reg;
    logic [4:0]  tenant_len_reg;
    logic [63:0] tenant_low_reg;
    logic [63:0] tenant_high_reg;

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_go;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  verdict_reg, verdict_next;
    logic        prepend_reg, prepend_next;

    logic [7:0]          folded;
    logic [4:0]          tenant_eff;
    logic                tenant_on;
    logic [8*DEPTH-1:0]  window;
    logic [CNT_W-1:0]    bytes_taken;
    logic [NUM_SEEN-1:0] hits;
    qry_sum_t            summary;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            admin_reg       <= 1'b0;
            tenant_len_reg  <= '0;
            tenant_low_reg  <= '0;
            tenant_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ADMIN:       admin_reg       <= cfg_data[0];
                CFG_TENANT_LEN:  tenant_len_reg  <= cfg_data[4:0];
                CFG_TENANT_LOW:  tenant_low_reg  <= cfg_data;
                CFG_TENANT_HIGH: tenant_high_reg <= cfg_data;
                default:         admin_reg       <= admin_reg;
            endcase
        end
    end

    assign tenant_eff = (tenant_len_reg > 5'(MAX_TENANT_BYTES)) ?
                        5'(MAX_TENANT_BYTES) : tenant_len_reg;
    assign tenant_on  = (tenant_eff != 5'd0);

    // input stage: only a last item waits on a full result register that is stalled
    assign s1_go    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= query_byte;
            s1_last_reg <= last_byte;
        end
    end

    assign folded = fold_lower(s1_byte_reg);

    sqkg_match #(
        .CNT_W            (CNT_W),
        .DEPTH            (DEPTH)
    ) u_match (
        .cur_byte    (folded),
        .window      (window),
        .bytes_taken (bytes_taken),
        .tenant_len  (tenant_eff),
        .tenant_low  (tenant_low_reg),
        .tenant_high (tenant_high_reg),
        .hits        (hits)
    );

    sqkg_track #(
        .MAX_QUERY_BYTES (MAX_QUERY_BYTES),
        .CNT_W           (CNT_W),
        .DEPTH           (DEPTH)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (s1_go),
        .last        (s1_last_reg),
        .cur_byte    (folded),
        .hits        (hits),
        .window      (window),
        .bytes_taken (bytes_taken),
        .summary     (summary)
    );

    // verdict of the query closed by the current item
    always_comb
    begin
        verdict_next = VERDICT_OK;
        prepend_next = 1'b0;
        if (summary.nonempty)
        begin
            if (!admin_reg && (|summary.seen[SEEN_DESTR_HI:0]))
            begin
                verdict_next = VERDICT_DESTR;
            end
            else if ((|summary.seen[SEEN_MARK_HI:SEEN_MARK_LO]) && tenant_on &&
                     summary.seen[SEEN_CLAUSE] && !summary.seen[SEEN_FORGED])
            begin
                verdict_next = VERDICT_BYPASS;
            end
            else
            begin
                prepend_next = tenant_on;
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            verdict_reg <= verdict_next;
            prepend_reg <= prepend_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign prepend_tenant = prepend_reg;

endmodule

>>> hdl/sqkg_checker.sv
// sqkg_checker: port-level assertions for sql_keyword_guard_top, bound to it below
// depends on sqkg_pkg
module sqkg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  query_byte,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  verdict,
    input logic        prepend_tenant,
    input logic        cfg_we,
    input logic [1:0]  cfg_index,
    input logic [63:0] cfg_data
);
    import sqkg_pkg::*;

    // a stalled verdict holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict) &&
        $stable(prepend_tenant))
        else $error("verdict changed while stalled");

    // only the three defined verdict codes appear
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == VERDICT_OK || verdict == VERDICT_DESTR ||
                       verdict == VERDICT_BYPASS))
        else $error("undefined verdict code");

    // the tenant prefix goes only with an ok verdict
    a_prepend_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && prepend_tenant |-> verdict == VERDICT_OK)
        else $error("prefix flagged on a blocked query");

    // input backpressure only comes from a stalled verdict
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without an output stall");

endmodule

bind sql_keyword_guard_top sqkg_checker u_sqkg_checker (.*);
